### rtl/assert_macros.svh
// Assertion macros shared by the thermostat RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain property on every clock edge outside reset.
`define SHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define SHT_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

### rtl/sht_pkg.sv
// Types and constants shared by the scheduled hysteresis thermostat.
`timescale 1ns / 1ps

package sht_pkg;

   // Widths of the fixed item fields
   localparam int TEMP_W  = 16;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int DAY_W   = 3;
   localparam int DAYS_W  = 7;
   localparam int INDEX_W = 3;
   localparam int COUNT_W = 4;
   localparam int HYST_W  = 10;
   localparam int CSR_W   = 16;

   // Item opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_ENABLE      = 3'd0;
   localparam logic [2:0] CSR_ENTRY_COUNT = 3'd1;
   localparam logic [2:0] CSR_HYSTERESIS  = 3'd2;
   localparam logic [2:0] CSR_MIN_TEMP    = 3'd3;
   localparam logic [2:0] CSR_MAX_TEMP    = 3'd4;

   // Weekday code that matches no mask bit
   localparam logic [DAY_W-1:0] DAY_NONE = 3'd7;

   // Configuration reset values
   localparam logic [HYST_W-1:0]        HYST_RESET = 10'd50;
   localparam logic signed [TEMP_W-1:0] MIN_RESET  = -16'sd4000;
   localparam logic signed [TEMP_W-1:0] MAX_RESET  = 16'sd10000;

   // One schedule slot as held in the table memory
   typedef struct packed {
      logic [DAYS_W-1:0]        days;
      logic [HOUR_W-1:0]        hour;
      logic [MIN_W-1:0]         minute;
      logic signed [TEMP_W-1:0] temp;
   } entry_type;

   // Evaluation request from the scan sequencer to the report stage
   typedef struct packed {
      logic                     fire;
      logic                     enable;
      logic signed [TEMP_W-1:0] cur;
      logic signed [TEMP_W-1:0] des;
   } eval_req_type;

endpackage

### rtl/sht_mem.sv
// Schedule table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sht_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  sht_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output sht_pkg::entry_type rd_data
);

   sht_pkg::entry_type mem_ff [DEPTH];
   sht_pkg::entry_type rd_data_ff;

   // Write slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read slot, data valid next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sht_eval.sv
// Hysteresis relay control, report tracking and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sht_eval (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sht_pkg::eval_req_type                 req,
   input  logic [sht_pkg::HYST_W-1:0]            hysteresis,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_relay_on,
   output logic                                  rsp_relay_changed,
   output logic                                  rsp_enabled_out,
   output logic signed [sht_pkg::TEMP_W-1:0]     rsp_current_temp,
   output logic signed [sht_pkg::TEMP_W-1:0]     rsp_desired_temp,
   output logic                                  rsp_state_changed
);

   logic                             relay_ff, relay_in;
   logic                             rsp_valid_ff;
   logic                             changed_ff, changed_in;
   logic                             toggled_ff;
   logic                             en_out_ff;
   logic signed [sht_pkg::TEMP_W-1:0] cur_out_ff, des_out_ff;
   logic                             last_valid_ff;
   logic                             last_on_ff, last_relay_ff;
   logic signed [sht_pkg::TEMP_W-1:0] last_cur_ff, last_des_ff;

   logic signed [sht_pkg::TEMP_W+1:0] cur_x, des_x, hyst_x, band_lo, band_hi;
   logic                             rep_relay;
   logic signed [sht_pkg::TEMP_W-1:0] rep_cur, rep_des;

   // Band edges at two extra bits so the sums cannot wrap
   always_comb begin
      cur_x   = {{2{req.cur[sht_pkg::TEMP_W-1]}}, req.cur};
      des_x   = {{2{req.des[sht_pkg::TEMP_W-1]}}, req.des};
      hyst_x  = {{(sht_pkg::TEMP_W + 2 - sht_pkg::HYST_W){1'b0}}, hysteresis};
      band_lo = des_x - hyst_x;
      band_hi = des_x + hyst_x;
   end

   // Switch relay: force off, turn on low, turn off high, else hold
   always_comb begin
      priority if (!req.enable || req.des == '0 || req.cur == '0) begin
         relay_in = 1'b0;
      end else if (cur_x <= band_lo) begin
         relay_in = 1'b1;
      end else if (cur_x >= band_hi) begin
         relay_in = 1'b0;
      end else begin
         relay_in = relay_ff;
      end
   end

   // Build the report and compare against the last one
   always_comb begin
      rep_relay  = req.enable & relay_in;
      rep_cur    = req.enable ? req.cur : '0;
      rep_des    = req.enable ? req.des : '0;
      changed_in = !last_valid_ff || (req.enable != last_on_ff) ||
                   (rep_relay != last_relay_ff) || (rep_cur != last_cur_ff) ||
                   (rep_des != last_des_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         en_out_ff     <= 1'b0;
         last_valid_ff <= 1'b0;
         last_on_ff    <= 1'b0;
         last_relay_ff <= 1'b0;
         last_cur_ff   <= '0;
         last_des_ff   <= '0;
      end else if (req.fire) begin
         relay_ff      <= relay_in;
         rsp_valid_ff  <= 1'b1;
         en_out_ff     <= req.enable;
         last_valid_ff <= 1'b1;
         last_on_ff    <= req.enable;
         last_relay_ff <= rep_relay;
         last_cur_ff   <= rep_cur;
         last_des_ff   <= rep_des;
      end else if (rsp_ready) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req.fire) begin
         toggled_ff <= relay_in ^ relay_ff;
         changed_ff <= changed_in;
         cur_out_ff <= rep_cur;
         des_out_ff <= rep_des;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_relay_on      = relay_ff;
   assign rsp_relay_changed = toggled_ff;
   assign rsp_enabled_out   = en_out_ff;
   assign rsp_current_temp  = cur_out_ff;
   assign rsp_desired_temp  = des_out_ff;
   assign rsp_state_changed = changed_ff;

   `SHT_ASSERT(a_relay_needs_enable, !relay_ff || en_out_ff, "relay on while disabled")
   `SHT_ASSERT_IMPL(a_fire_into_free_slot, req.fire, !rsp_valid_ff || rsp_ready, "result overwritten")
   `SHT_ASSERT_IMPL(a_relay_needs_temps, rsp_valid_ff && relay_ff, cur_out_ff != '0 && des_out_ff != '0, "relay on with zero temperature")

endmodule

### rtl/scheduled_hysteresis_thermostat.sv
// Scheduled hysteresis thermostat: item intake, schedule scan sequencer, configuration.
// A write item is taken while idle and gives no result. A tick scans slots from the highest
// in use downward, one table read per cycle, and stops at the first match; it reads at most
// min(entry_count, ENTRIES) slots, and none when disabled or with no slots in use.
// A tick keeps req_ready low until evaluated, also while the result waits on rsp_ready.
// Synchronous reset clears control and loads register defaults; table contents are kept.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scheduled_hysteresis_thermostat #(
   parameter int ENTRIES = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic [sht_pkg::HOUR_W-1:0]            req_hour,
   input  logic [sht_pkg::MIN_W-1:0]             req_minute,
   input  logic [sht_pkg::DAY_W-1:0]             req_day_of_week,
   input  logic signed [sht_pkg::TEMP_W-1:0]     req_sensor_temp,
   input  logic [sht_pkg::INDEX_W-1:0]           req_entry_index,
   input  logic [sht_pkg::DAYS_W-1:0]            req_entry_days,
   input  logic signed [sht_pkg::TEMP_W-1:0]     req_entry_temp,
   // Result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_relay_on,
   output logic                                  rsp_relay_changed,
   output logic                                  rsp_enabled_out,
   output logic signed [sht_pkg::TEMP_W-1:0]     rsp_current_temp,
   output logic signed [sht_pkg::TEMP_W-1:0]     rsp_desired_temp,
   output logic                                  rsp_state_changed,
   // Configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [sht_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [7:0] ENTRIES_W8 = 8'(ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic                                   enable_ff;
   logic [sht_pkg::COUNT_W-1:0]            count_ff;
   logic [sht_pkg::HYST_W-1:0]             hyst_ff;
   logic signed [sht_pkg::TEMP_W-1:0]      min_ff, max_ff;

   // Tick context
   logic [sht_pkg::HOUR_W-1:0]             hour_ff, hour_in;
   logic [sht_pkg::MIN_W-1:0]              minute_ff, minute_in;
   logic [sht_pkg::DAY_W-1:0]              day_ff, day_in;
   logic signed [sht_pkg::TEMP_W-1:0]      cur_ff, cur_in;
   logic signed [sht_pkg::TEMP_W-1:0]      des_ff, des_in;
   logic [AW-1:0]                          ptr_ff, ptr_in;

   logic                                   in_acc, tick_acc, write_acc;
   logic [7:0]                             cnt_lim;
   logic [AW-1:0]                          first_addr;
   logic                                   rd_en;
   logic [AW-1:0]                          rd_addr;
   sht_pkg::entry_type                     rd_data, wr_data;
   logic                                   wr_en;
   logic                                   slot_hit, out_free;
   logic                                   rsp_valid_int;
   sht_pkg::eval_req_type                  eval_req;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign in_acc    = req_valid && req_ready;
   assign tick_acc  = in_acc && (req_opcode == sht_pkg::OP_TICK);
   assign write_acc = in_acc && (req_opcode == sht_pkg::OP_WRITE);
   assign out_free  = !rsp_valid_int || rsp_ready;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
         hyst_ff   <= sht_pkg::HYST_RESET;
         min_ff    <= sht_pkg::MIN_RESET;
         max_ff    <= sht_pkg::MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sht_pkg::CSR_ENABLE:      enable_ff <= csr_wdata[0];
            sht_pkg::CSR_ENTRY_COUNT: count_ff  <= csr_wdata[sht_pkg::COUNT_W-1:0];
            sht_pkg::CSR_HYSTERESIS:  hyst_ff   <= csr_wdata[sht_pkg::HYST_W-1:0];
            sht_pkg::CSR_MIN_TEMP:    min_ff    <= $signed(csr_wdata[sht_pkg::TEMP_W-1:0]);
            sht_pkg::CSR_MAX_TEMP:    max_ff    <= $signed(csr_wdata[sht_pkg::TEMP_W-1:0]);
            default: ;
         endcase
      end
   end

   // Load slots; drop writes past the table
   always_comb begin
      wr_en          = write_acc && ({5'b0, req_entry_index} < ENTRIES_W8);
      wr_data.days   = req_entry_days;
      wr_data.hour   = req_hour;
      wr_data.minute = req_minute;
      wr_data.temp   = req_entry_temp;
   end

   // Clamp the slot count to the table depth
   always_comb begin
      cnt_lim    = ({4'b0, count_ff} > ENTRIES_W8) ? ENTRIES_W8 : {4'b0, count_ff};
      first_addr = AW'(cnt_lim - 8'd1);
   end

   // Match the slot read last cycle against the tick time
   always_comb begin
      slot_hit = (day_ff != sht_pkg::DAY_NONE) && rd_data.days[day_ff] &&
                 ((hour_ff > rd_data.hour) ||
                  ((hour_ff == rd_data.hour) && (minute_ff >= rd_data.minute)));
   end

   // Sequence intake, scan and evaluation
   always_comb begin
      state_in  = state_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      day_in    = day_ff;
      cur_in    = cur_ff;
      des_in    = des_ff;
      ptr_in    = ptr_ff;
      rd_en     = 1'b0;
      rd_addr   = first_addr;
      eval_req  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               hour_in   = req_hour;
               minute_in = req_minute;
               day_in    = req_day_of_week;
               cur_in    = ((req_sensor_temp < min_ff) || (req_sensor_temp > max_ff)) ?
                           '0 : req_sensor_temp;
               des_in    = '0;
               if (enable_ff && (cnt_lim != 8'd0)) begin
                  rd_en    = 1'b1;
                  ptr_in   = first_addr;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = ptr_ff - AW'(1);
            if (slot_hit) begin
               des_in   = rd_data.temp;
               state_in = ST_EVAL;
            end else if (ptr_ff == '0) begin
               des_in   = '0;
               state_in = ST_EVAL;
            end else begin
               rd_en    = 1'b1;
               ptr_in   = ptr_ff - AW'(1);
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               eval_req.fire   = 1'b1;
               eval_req.enable = enable_ff;
               eval_req.cur    = cur_ff;
               eval_req.des    = des_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Advance sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Hold tick context
   always_ff @(posedge clock) begin
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      day_ff    <= day_in;
      cur_ff    <= cur_in;
      des_ff    <= des_in;
   end

   sht_mem #(
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sht_eval u_eval (
      .clock             (clock),
      .reset             (reset),
      .req               (eval_req),
      .hysteresis        (hyst_ff),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid_int),
      .rsp_relay_on      (rsp_relay_on),
      .rsp_relay_changed (rsp_relay_changed),
      .rsp_enabled_out   (rsp_enabled_out),
      .rsp_current_temp  (rsp_current_temp),
      .rsp_desired_temp  (rsp_desired_temp),
      .rsp_state_changed (rsp_state_changed)
   );

   assign rsp_valid = rsp_valid_int;

   `SHT_ASSERT_IMPL(a_tick_busy, $past(tick_acc) && !$past(reset), !req_ready, "busy")
   `SHT_ASSERT_IMPL(a_rsp_eval, $rose(rsp_valid_int), $past(state_ff == ST_EVAL), "no eval")

endmodule
